@@ src/ansi_text_terminal_engine_defines.svh @@
// Assertion macros shared by the terminal engine RTL.
`ifndef ANSI_TEXT_TERMINAL_ENGINE_DEFINES_SVH
`define ANSI_TEXT_TERMINAL_ENGINE_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define ATTE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ATTE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/atte_pkg.sv @@
// Package with the constants and widths of the terminal engine.
`timescale 1ns / 1ps
`default_nettype none
package atte_pkg;
   localparam int ROWS_DEF        = 25;
   localparam int COLS_DEF        = 80;
   localparam int MAX_PARAMS_DEF  = 16;
   localparam int TAB_SPACING_DEF = 8;

   localparam int CHAR_W = 8;
   localparam int ATTR_W = 7;
   localparam int CELL_W = CHAR_W + ATTR_W;
   localparam int PVAL_W = 16;
   localparam int FROW_W = 5;
   localparam int FCOL_W = 7;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 7'h07;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
   localparam logic [CHAR_W-1:0] CH_BEL       = 8'h07;
   localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF        = 8'h0a;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'h0d;
   localparam logic [CHAR_W-1:0] CH_ESC       = 8'h1b;
   localparam logic [CHAR_W-1:0] CH_LBRACKET  = 8'h5b;
   localparam logic [CHAR_W-1:0] CH_SEMI      = 8'h3b;
   localparam logic [PVAL_W-1:0] PARAM_SAT    = 16'hffff;

   localparam logic [CELL_W-1:0] CELL_BLANK = {CH_SPACE, ATTR_DEFAULT};
endpackage
`default_nettype wire

@@ src/ansi_text_terminal_engine.sv @@
// Top level of the terminal engine: escape parser, cursor logic and cell memory.
//
//  channel | direction | ports          | word
//  req     | in        | req_t*         | tuser = op; tdata = byte, read row, read col
//  rsp     | out       | rsp_t*         | tdata = cell, cursor, scrolled flag
//
// One word is worked on at a time; a plain byte passes through accept,
// execute and loading the result register, and a read adds a step between
// execute and the result, since the cell memory output is registered.
// Erase to end of line, a scrolling line feed and clear screen write the cell
// memory one cell a cycle: from the cursor to the line end, the old top row
// and the whole grid. A tab steps one stop per cycle, and a colour sequence
// reads each parameter from the parameter memory and then applies it.
// After reset, a clearing pass fills the grid with blanks before the first
// word is taken. A stalled result holds the engine in its last step; a new
// word is taken as soon as the previous result is loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "ansi_text_terminal_engine_defines.svh"
module ansi_text_terminal_engine #(
   parameter int ROWS        = atte_pkg::ROWS_DEF,
   parameter int COLS        = atte_pkg::COLS_DEF,
   parameter int MAX_PARAMS  = atte_pkg::MAX_PARAMS_DEF,
   parameter int TAB_SPACING = atte_pkg::TAB_SPACING_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tuser: op (0 feeds a byte, 1 reads a cell)
   input  wire logic                            req_tuser,
   // tdata: data_byte [7:0], read_row [12:8], read_col [19:13], zeros above
   input  wire logic [atte_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: cell_char [7:0], cell_fg [10:8], cell_bg [13:11], cell_bold [14],
   // cursor_row [19:15], cursor_col [26:20], scrolled [27], zeros above
   output logic [atte_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import atte_pkg::*;

   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W  = $clog2(COLS);
   localparam int PHR_W  = ROW_W + 1;
   localparam int DEPTH  = ROWS * COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PC_W   = $clog2(MAX_PARAMS + 2);
   localparam int PI_W   = $clog2(MAX_PARAMS);
   localparam int TM_W   = $clog2(COLS + TAB_SPACING + 1);

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EXEC   = 4'd1;
   localparam logic [3:0] S_RDW    = 4'd2;
   localparam logic [3:0] S_FILL   = 4'd3;
   localparam logic [3:0] S_PUT    = 4'd4;
   localparam logic [3:0] S_TAB    = 4'd5;
   localparam logic [3:0] S_SGR_RD = 4'd6;
   localparam logic [3:0] S_SGR_AP = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   // Escape parser phases.
   localparam logic [1:0] PH_NORMAL  = 2'd0;
   localparam logic [1:0] PH_BRACKET = 2'd1;
   localparam logic [1:0] PH_PARAM   = 2'd2;
   localparam logic [1:0] PH_INTER   = 2'd3;

   // Where a fill sweep continues when it ends.
   localparam logic [1:0] RET_IDLE = 2'd0;
   localparam logic [1:0] RET_DONE = 2'd1;
   localparam logic [1:0] RET_PUT  = 2'd2;

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);

   // Cell memory: character in the upper byte, attribute below it.
   logic [CELL_W-1:0] cell_mem [DEPTH];
   logic [CELL_W-1:0] mem_rd_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [CELL_W-1:0] mem_wdata;

   // Parameter memory of the escape parser.
   logic [PVAL_W-1:0] param_mem [MAX_PARAMS];
   logic [PVAL_W-1:0] prd_ff;
   logic              pmem_we;
   logic [PI_W-1:0]   pmem_waddr, pmem_raddr;
   logic [PVAL_W-1:0] pmem_wdata;

   logic [3:0]        state_ff, state_in;
   logic              op_ff, op_in;
   logic [7:0]        byte_ff, byte_in;
   logic [FROW_W-1:0] rrow_ff, rrow_in;
   logic [FCOL_W-1:0] rcol_ff, rcol_in;
   logic [1:0]        phase_ff, phase_in;
   logic [PC_W-1:0]   pcount_ff, pcount_in;
   logic              popen_ff, popen_in;
   logic              pbad_ff, pbad_in;
   logic [PVAL_W-1:0] acc_ff, acc_in;
   logic [PVAL_W-1:0] p0_ff, p0_in;
   logic [PVAL_W-1:0] p1_ff, p1_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  sav_row_ff, sav_row_in;
   logic [COL_W-1:0]  sav_col_ff, sav_col_in;
   logic              wrap_ff, wrap_in;
   logic [ATTR_W-1:0] pen_ff, pen_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ADDR_W-1:0] fill_addr_ff, fill_addr_in;
   logic [ADDR_W-1:0] fill_last_ff, fill_last_in;
   logic [CELL_W-1:0] fill_dat_ff, fill_dat_in;
   logic [1:0]        ret_ff, ret_in;
   logic [TM_W-1:0]   tab_m_ff, tab_m_in;
   logic [PC_W-1:0]   sgr_i_ff, sgr_i_in;
   logic [PC_W-1:0]   sgr_n_ff, sgr_n_in;
   logic              scr_ff, scr_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Physical base address of a screen row under the rotating top line.
   function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] top,
                                                   input logic [ROW_W-1:0] row);
      logic [PHR_W-1:0] phys;
      phys = {1'b0, top} + {1'b0, row};
      if (phys >= PHR_W'(ROWS)) phys = phys - PHR_W'(ROWS);
      return ADDR_W'(phys * COLS);
   endfunction

   logic [ADDR_W-1:0] cur_base;
   logic              req_fire;
   logic              mv;
   logic [ROW_W-1:0]  mv_row;
   logic [COL_W-1:0]  mv_col;
   logic [PC_W-1:0]   pnum, cnt_n;
   logic              has1, has2;
   logic [PVAL_W-1:0] v1, v2, pbase, pnew;
   logic [PVAL_W+4:0] prod;
   logic [PVAL_W:0]   rsum;
   logic [PVAL_W:0]   csum;
   logic [PVAL_W-1:0] sv;

   assign cur_base   = row_base(top_ff, cur_row_ff);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign pnum = (pcount_ff > PC_W'(MAX_PARAMS)) ? PC_W'(MAX_PARAMS) : pcount_ff;
   assign has1 = (pcount_ff != '0);
   assign has2 = (pcount_ff >= PC_W'(2));
   assign v1   = (has1 && p0_ff != '0) ? p0_ff : PVAL_W'(1);
   assign v2   = (has2 && p1_ff != '0) ? p1_ff : PVAL_W'(1);
   assign sv   = prd_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      byte_in      = byte_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      phase_in     = phase_ff;
      pcount_in    = pcount_ff;
      popen_in     = popen_ff;
      pbad_in      = pbad_ff;
      acc_in       = acc_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      sav_row_in   = sav_row_ff;
      sav_col_in   = sav_col_ff;
      wrap_in      = wrap_ff;
      pen_in       = pen_ff;
      top_in       = top_ff;
      fill_addr_in = fill_addr_ff;
      fill_last_in = fill_last_ff;
      fill_dat_in  = fill_dat_ff;
      ret_in       = ret_ff;
      tab_m_in     = tab_m_ff;
      sgr_i_in     = sgr_i_ff;
      sgr_n_in     = sgr_n_ff;
      scr_in       = scr_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_base + ADDR_W'(cur_col_ff);
      mem_wdata    = {byte_ff, pen_ff};
      mem_raddr    = row_base(top_ff, ROW_W'(rrow_ff)) + ADDR_W'(rcol_ff);
      pmem_we      = 1'b0;
      pmem_waddr   = '0;
      pmem_wdata   = '0;
      pmem_raddr   = sgr_i_ff[PI_W-1:0];
      mv           = 1'b0;
      mv_row       = cur_row_ff;
      mv_col       = cur_col_ff;
      cnt_n        = pcount_ff;
      pbase        = '0;
      prod         = '0;
      pnew         = '0;
      rsum         = '0;
      csum         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_tuser;
               byte_in  = req_tdata[7:0];
               rrow_in  = req_tdata[12:8];
               rcol_in  = req_tdata[19:13];
               scr_in   = 1'b0;
               cell_in  = '0;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_DONE;
            if (op_ff) begin
               if (32'(rrow_ff) < ROWS && 32'(rcol_ff) < COLS) begin
                  state_in = S_RDW;
               end
            end else begin
               case (phase_ff)
                  PH_BRACKET: begin
                     phase_in = (byte_ff == CH_LBRACKET) ? PH_PARAM : PH_NORMAL;
                  end
                  PH_PARAM, PH_INTER: begin
                     if (phase_ff == PH_PARAM && byte_ff inside {[8'h30:8'h3f]}) begin
                        if (byte_ff inside {[8'h30:8'h39]}) begin
                           // Digit: open a parameter if needed, then accumulate.
                           if (!popen_ff && pcount_ff <= PC_W'(MAX_PARAMS)) begin
                              cnt_n = pcount_ff + PC_W'(1);
                           end
                           pbase = popen_ff ? acc_ff : '0;
                           if (cnt_n <= PC_W'(MAX_PARAMS)) begin
                              prod = (PVAL_W+5)'(pbase) * (PVAL_W+5)'(10)
                                   + (PVAL_W+5)'(byte_ff - 8'h30);
                              pnew = (prod > (PVAL_W+5)'(PARAM_SAT)) ? PARAM_SAT
                                                                      : prod[PVAL_W-1:0];
                              acc_in     = pnew;
                              pmem_we    = 1'b1;
                              pmem_waddr = PI_W'(cnt_n - PC_W'(1));
                              pmem_wdata = pnew;
                              if (cnt_n == PC_W'(1)) p0_in = pnew;
                              if (cnt_n == PC_W'(2)) p1_in = pnew;
                           end
                           pcount_in = cnt_n;
                           popen_in  = 1'b1;
                        end else if (byte_ff == CH_SEMI) begin
                           popen_in = 1'b0;
                        end else begin
                           pbad_in = 1'b1;
                        end
                     end else if (byte_ff inside {[8'h20:8'h2f]}) begin
                        phase_in = PH_INTER;
                     end else begin
                        phase_in = PH_NORMAL;
                        if (byte_ff inside {[8'h40:8'h7e]} && !pbad_ff) begin
                           case (byte_ff)
                              8'h41: begin // A: up
                                 mv = 1'b1;
                                 mv_row = (v1 >= PVAL_W'(cur_row_ff)) ? '0
                                        : cur_row_ff - ROW_W'(v1);
                              end
                              8'h42: begin // B: down
                                 mv = 1'b1;
                                 rsum = (PVAL_W+1)'(cur_row_ff) + (PVAL_W+1)'(v1);
                                 mv_row = (rsum > (PVAL_W+1)'(ROWS - 1)) ? LAST_ROW
                                        : ROW_W'(rsum);
                              end
                              8'h43: begin // C: right
                                 mv = 1'b1;
                                 csum = (PVAL_W+1)'(cur_col_ff) + (PVAL_W+1)'(v1);
                                 mv_col = (csum > (PVAL_W+1)'(COLS - 1)) ? LAST_COL
                                        : COL_W'(csum);
                              end
                              8'h44: begin // D: left
                                 mv = 1'b1;
                                 mv_col = (v1 >= PVAL_W'(cur_col_ff)) ? '0
                                        : cur_col_ff - COL_W'(v1);
                              end
                              8'h48: begin // H: absolute position, one-based
                                 mv = 1'b1;
                                 mv_row = (v1 >= PVAL_W'(ROWS)) ? LAST_ROW
                                        : ROW_W'(v1 - PVAL_W'(1));
                                 mv_col = (v2 >= PVAL_W'(COLS)) ? LAST_COL
                                        : COL_W'(v2 - PVAL_W'(1));
                              end
                              8'h4a: begin // J: clear screen for mode 2 or 3
                                 if (has1 && (p0_ff == PVAL_W'(2) || p0_ff == PVAL_W'(3))) begin
                                    mv           = 1'b1;
                                    mv_row       = '0;
                                    mv_col       = '0;
                                    fill_addr_in = '0;
                                    fill_last_in = ADDR_W'(DEPTH - 1);
                                    fill_dat_in  = CELL_BLANK;
                                    ret_in       = RET_DONE;
                                    state_in     = S_FILL;
                                 end
                              end
                              8'h4b: begin // K: erase to end of line for mode 0
                                 if (!has1 || p0_ff == '0) begin
                                    fill_addr_in = cur_base + ADDR_W'(cur_col_ff);
                                    fill_last_in = cur_base + ADDR_W'(COLS - 1);
                                    fill_dat_in  = {CH_SPACE, pen_ff};
                                    ret_in       = RET_DONE;
                                    state_in     = S_FILL;
                                 end
                              end
                              8'h6d: begin // m: select graphic rendition
                                 if (pnum == '0) begin
                                    pen_in = ATTR_DEFAULT;
                                 end else begin
                                    sgr_i_in = '0;
                                    sgr_n_in = pnum;
                                    state_in = S_SGR_RD;
                                 end
                              end
                              8'h73: begin // s
                                 sav_row_in = cur_row_ff;
                                 sav_col_in = cur_col_ff;
                              end
                              8'h75: begin // u
                                 mv     = 1'b1;
                                 mv_row = sav_row_ff;
                                 mv_col = sav_col_ff;
                              end
                              default: begin
                              end
                           endcase
                        end
                     end
                  end
                  default: begin // normal text
                     case (byte_ff)
                        CH_NUL, CH_BEL: begin
                        end
                        CH_ESC: begin
                           phase_in  = PH_BRACKET;
                           pcount_in = '0;
                           popen_in  = 1'b0;
                           pbad_in   = 1'b0;
                        end
                        CH_BS: begin
                           if (cur_col_ff != '0) begin
                              mv        = 1'b1;
                              mv_col    = cur_col_ff - COL_W'(1);
                              mem_we    = 1'b1;
                              mem_waddr = cur_base + ADDR_W'(mv_col);
                              mem_wdata = {CH_SPACE, pen_ff};
                           end
                        end
                        CH_TAB: begin
                           tab_m_in = '0;
                           state_in = S_TAB;
                        end
                        CH_CR: begin
                           mv     = 1'b1;
                           mv_col = '0;
                        end
                        CH_LF: begin
                           mv     = 1'b1;
                           mv_col = '0;
                           if (cur_row_ff == LAST_ROW) begin
                              // Scroll: blank the old top row, which becomes the bottom.
                              fill_addr_in = row_base(top_ff, '0);
                              fill_last_in = row_base(top_ff, '0) + ADDR_W'(COLS - 1);
                              fill_dat_in  = CELL_BLANK;
                              ret_in       = RET_DONE;
                              state_in     = S_FILL;
                              top_in = (top_ff == LAST_ROW) ? '0 : top_ff + ROW_W'(1);
                              scr_in = 1'b1;
                           end else begin
                              mv_row = cur_row_ff + ROW_W'(1);
                           end
                        end
                        default: begin // printable
                           if (cur_col_ff != LAST_COL) begin
                              mem_we = 1'b1;
                              mv     = 1'b1;
                              mv_col = cur_col_ff + COL_W'(1);
                           end else if (wrap_ff) begin
                              // Delayed wrap: line feed first, then write at column 0.
                              wrap_in = 1'b0;
                              mv      = 1'b1;
                              mv_col  = '0;
                              if (cur_row_ff == LAST_ROW) begin
                                 fill_addr_in = row_base(top_ff, '0);
                                 fill_last_in = row_base(top_ff, '0) + ADDR_W'(COLS - 1);
                                 fill_dat_in  = CELL_BLANK;
                                 ret_in       = RET_PUT;
                                 state_in     = S_FILL;
                                 top_in = (top_ff == LAST_ROW) ? '0 : top_ff + ROW_W'(1);
                                 scr_in = 1'b1;
                              end else begin
                                 mv_row   = cur_row_ff + ROW_W'(1);
                                 state_in = S_PUT;
                              end
                           end else begin
                              wrap_in = 1'b1;
                              mem_we  = 1'b1;
                           end
                        end
                     endcase
                  end
               endcase
            end
         end

         S_RDW: begin
            cell_in  = mem_rd_ff;
            state_in = S_DONE;
         end

         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = fill_addr_ff;
            mem_wdata = fill_dat_ff;
            if (fill_addr_ff == fill_last_ff) begin
               case (ret_ff)
                  RET_DONE: state_in = S_DONE;
                  RET_PUT:  state_in = S_PUT;
                  default:  state_in = S_IDLE;
               endcase
            end else begin
               fill_addr_in = fill_addr_ff + ADDR_W'(1);
            end
         end

         S_PUT: begin
            // Cursor sits at column 0 of the new line here.
            mem_we     = 1'b1;
            cur_col_in = COL_W'(1);
            wrap_in    = 1'b0;
            state_in   = S_DONE;
         end

         S_TAB: begin
            if (tab_m_ff >= TM_W'(cur_col_ff)) begin
               mv       = 1'b1;
               mv_col   = (tab_m_ff > TM_W'(COLS - 1)) ? LAST_COL : COL_W'(tab_m_ff);
               state_in = S_DONE;
            end else begin
               tab_m_in = tab_m_ff + TM_W'(TAB_SPACING);
            end
         end

         S_SGR_RD: begin
            state_in = S_SGR_AP;
         end

         S_SGR_AP: begin
            if (sv == '0) begin
               pen_in = ATTR_DEFAULT;
            end else if (sv == PVAL_W'(1)) begin
               pen_in = pen_ff | 7'h40;
            end else if (sv >= PVAL_W'(30) && sv <= PVAL_W'(37)) begin
               pen_in = {pen_ff[6:3], 3'(sv - PVAL_W'(30))};
            end else if (sv >= PVAL_W'(40) && sv <= PVAL_W'(47)) begin
               pen_in = {pen_ff[6], 3'(sv - PVAL_W'(40)), pen_ff[2:0]};
            end
            sgr_i_in = sgr_i_ff + PC_W'(1);
            state_in = (sgr_i_ff + PC_W'(1) == sgr_n_ff) ? S_DONE : S_SGR_RD;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, scr_ff, FCOL_W'(cur_col_ff), FROW_W'(cur_row_ff),
                               cell_ff[6], cell_ff[5:3], cell_ff[2:0], cell_ff[14:7]};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (mv) begin
         cur_row_in = mv_row;
         cur_col_in = mv_col;
         if (mv_col != LAST_COL) wrap_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         phase_ff     <= PH_NORMAL;
         pcount_ff    <= '0;
         popen_ff     <= 1'b0;
         pbad_ff      <= 1'b0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         sav_row_ff   <= '0;
         sav_col_ff   <= '0;
         wrap_ff      <= 1'b0;
         pen_ff       <= ATTR_DEFAULT;
         top_ff       <= '0;
         fill_addr_ff <= '0;
         fill_last_ff <= ADDR_W'(DEPTH - 1);
         fill_dat_ff  <= CELL_BLANK;
         ret_ff       <= RET_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pcount_ff    <= pcount_in;
         popen_ff     <= popen_in;
         pbad_ff      <= pbad_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         sav_row_ff   <= sav_row_in;
         sav_col_ff   <= sav_col_in;
         wrap_ff      <= wrap_in;
         pen_ff       <= pen_in;
         top_ff       <= top_in;
         fill_addr_ff <= fill_addr_in;
         fill_last_ff <= fill_last_in;
         fill_dat_ff  <= fill_dat_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      byte_ff     <= byte_in;
      rrow_ff     <= rrow_in;
      rcol_ff     <= rcol_in;
      acc_ff      <= acc_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      tab_m_ff    <= tab_m_in;
      sgr_i_ff    <= sgr_i_in;
      sgr_n_ff    <= sgr_n_in;
      scr_ff      <= scr_in;
      cell_ff     <= cell_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
      mem_rd_ff <= cell_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (pmem_we) param_mem[pmem_waddr] <= pmem_wdata;
      prd_ff <= param_mem[pmem_raddr];
   end

   `ATTE_ASSERT(a_cursor_on_screen, (32'(cur_row_ff) < ROWS) && (32'(cur_col_ff) < COLS), "cursor off screen")
   `ATTE_ASSERT(a_wrap_last_col, wrap_ff |-> (cur_col_ff == LAST_COL), "wrap pending away from last column")
   `ATTE_ASSERT(a_fill_bound, (state_ff == S_FILL) |-> (fill_addr_ff <= fill_last_ff), "fill sweep overran")
   `ATTE_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE), "result loaded outside result step")
   `ATTE_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid_ff, "result valid after reset")

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the ANSI text terminal engine, with its own terminal predictor.
`timescale 1ns / 1ps
module tb_top;
   import atte_pkg::*;

   localparam int NROWS = ROWS_DEF;
   localparam int NCOLS = COLS_DEF;
   localparam int NPARAMS = MAX_PARAMS_DEF;
   localparam int TABSTOP = TAB_SPACING_DEF;
   localparam int NCELLS = NROWS * NCOLS;
   localparam int IDLE_LIMIT = 40000;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef enum logic { OP_FEED = 1'b0, OP_READ = 1'b1 } term_op_type;
   typedef enum int { PH_NORMAL, PH_BRACKET, PH_PARAM, PH_INTER } esc_phase_type;

   typedef struct packed {
      term_op_type op;
      logic [7:0]  data_byte;
      logic [4:0]  read_row;
      logic [6:0]  read_col;
   } term_word_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [2:0] cell_fg;
      logic [2:0] cell_bg;
      logic       cell_bold;
      logic [4:0] cursor_row;
      logic [6:0] cursor_col;
      logic       scrolled;
   } screen_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic req_tuser = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   ansi_text_terminal_engine u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   term_word_type  words_to_send[$];
   screen_rsp_type screen_expected[$];
   int             failures = 0;
   int             words_accepted = 0;

   // Predictor state of the terminal.
   esc_phase_type phase;
   int          pvals[NPARAMS];
   int          pcount;
   bit          popen, pbad;
   int          crow, ccol, srow, scol;
   bit          wrap_pend;
   logic [6:0]  pen;
   logic [7:0]  grid_char[NCELLS];
   logic [6:0]  grid_attr[NCELLS];
   int          top_row;
   bit          scroll_flag;

   function automatic int cell_at(int r, int c);
      return ((top_row + r) % NROWS) * NCOLS + c;
   endfunction

   function automatic void put_char(int r, int c, logic [7:0] ch);
      grid_char[cell_at(r, c)] = ch;
      grid_attr[cell_at(r, c)] = pen;
   endfunction

   function automatic void goto_cell(int r, int c);
      crow = r;
      ccol = c;
      if (c != NCOLS - 1) wrap_pend = 1'b0;
   endfunction

   function automatic void new_line();
      if (crow == NROWS - 1) begin
         for (int c = 0; c < NCOLS; c++) begin
            grid_char[top_row * NCOLS + c] = CH_SPACE;
            grid_attr[top_row * NCOLS + c] = ATTR_DEFAULT;
         end
         top_row = (top_row + 1) % NROWS;
         scroll_flag = 1'b1;
         goto_cell(crow, 0);
      end else begin
         goto_cell(crow + 1, 0);
      end
   endfunction

   function automatic void execute_sequence(logic [7:0] fin);
      int n, v, r, c;
      n = (pcount < NPARAMS) ? pcount : NPARAMS;
      if (pbad) return;
      // An absent or zero count means one for the cursor moves.
      v = (n >= 1 && pvals[0] != 0) ? pvals[0] : 1;
      case (fin)
         "A": goto_cell((v >= crow) ? 0 : crow - v, ccol);
         "B": goto_cell((crow + v > NROWS - 1) ? NROWS - 1 : crow + v, ccol);
         "C": goto_cell(crow, (ccol + v > NCOLS - 1) ? NCOLS - 1 : ccol + v);
         "D": goto_cell(crow, (v >= ccol) ? 0 : ccol - v);
         "H": begin
            r = (v > NROWS) ? NROWS : v;
            c = (n >= 2 && pvals[1] != 0) ? pvals[1] : 1;
            if (c > NCOLS) c = NCOLS;
            goto_cell(r - 1, c - 1);
         end
         "J": begin
            v = (n >= 1) ? pvals[0] : 0;
            if (v == 2 || v == 3) begin
               for (int i = 0; i < NCELLS; i++) begin
                  grid_char[i] = CH_SPACE;
                  grid_attr[i] = ATTR_DEFAULT;
               end
               goto_cell(0, 0);
            end
         end
         "K": begin
            v = (n >= 1) ? pvals[0] : 0;
            if (v == 0)
               for (c = ccol; c < NCOLS; c++) put_char(crow, c, CH_SPACE);
         end
         "m": begin
            if (n == 0) pen = ATTR_DEFAULT;
            for (int i = 0; i < n; i++) begin
               v = pvals[i];
               if (v == 0) pen = ATTR_DEFAULT;
               else if (v == 1) pen[6] = 1'b1;
               else if (v >= 30 && v <= 37) pen[2:0] = 3'(v - 30);
               else if (v >= 40 && v <= 47) pen[5:3] = 3'(v - 40);
            end
         end
         "s": begin
            srow = crow;
            scol = ccol;
         end
         "u": goto_cell(srow, scol);
         default: ;
      endcase
   endfunction

   function automatic void param_char(logic [7:0] ch);
      int v;
      if (ch >= "0" && ch <= "9") begin
         if (!popen) begin
            if (pcount < NPARAMS) pvals[pcount] = 0;
            if (pcount <= NPARAMS) pcount++;
            popen = 1'b1;
         end
         if (pcount <= NPARAMS) begin
            v = pvals[pcount - 1] * 10 + (ch - "0");
            pvals[pcount - 1] = (v > 65535) ? 65535 : v;
         end
      end else if (ch == CH_SEMI) begin
         popen = 1'b0;
      end else begin
         pbad = 1'b1;
      end
   endfunction

   function automatic void feed_byte(logic [7:0] ch);
      int c;
      if (phase == PH_BRACKET) begin
         phase = (ch == CH_LBRACKET) ? PH_PARAM : PH_NORMAL;
         return;
      end
      if (phase == PH_PARAM) begin
         if (ch >= 8'h30 && ch <= 8'h3f) begin
            param_char(ch);
            return;
         end
         phase = PH_INTER;
      end
      if (phase == PH_INTER) begin
         if (ch >= 8'h20 && ch <= 8'h2f) return;
         phase = PH_NORMAL;
         if (ch >= 8'h40 && ch <= 8'h7e) execute_sequence(ch);
         return;
      end
      case (ch)
         CH_NUL, CH_BEL: return;
         CH_ESC: begin
            phase = PH_BRACKET;
            pcount = 0;
            popen = 1'b0;
            pbad = 1'b0;
            return;
         end
         CH_BS: begin
            if (ccol > 0) begin
               goto_cell(crow, ccol - 1);
               put_char(crow, ccol, CH_SPACE);
            end
            return;
         end
         CH_TAB: begin
            // The search starts at the cursor itself.
            for (c = ccol; c < NCOLS; c++)
               if (c % TABSTOP == 0 || c == NCOLS - 1) begin
                  goto_cell(crow, c);
                  return;
               end
            return;
         end
         CH_CR: begin
            goto_cell(crow, 0);
            return;
         end
         CH_LF: begin
            new_line();
            return;
         end
         default: ;
      endcase
      // Printable path with delayed wrap at the last column.
      if (ccol + 1 < NCOLS) begin
         put_char(crow, ccol, ch);
         goto_cell(crow, ccol + 1);
      end else if (wrap_pend) begin
         wrap_pend = 1'b0;
         new_line();
         put_char(crow, ccol, ch);
         goto_cell(crow, 1);
      end else begin
         wrap_pend = 1'b1;
         put_char(crow, ccol, ch);
      end
   endfunction

   function automatic screen_rsp_type predict_screen(term_word_type w);
      screen_rsp_type e;
      logic [6:0] at;
      e = '0;
      at = '0;
      scroll_flag = 1'b0;
      if (w.op == OP_FEED) begin
         feed_byte(w.data_byte);
      end else if (w.read_row < NROWS && w.read_col < NCOLS) begin
         e.cell_char = grid_char[cell_at(w.read_row, w.read_col)];
         at = grid_attr[cell_at(w.read_row, w.read_col)];
      end
      e.cell_fg = at[2:0];
      e.cell_bg = at[5:3];
      e.cell_bold = at[6];
      e.cursor_row = 5'(crow);
      e.cursor_col = 7'(ccol);
      e.scrolled = scroll_flag;
      return e;
   endfunction

   // Stimulus helpers: the row and column fields of a fed byte are random noise.
   function automatic void queue_byte(logic [7:0] b);
      term_word_type w;
      w.op = OP_FEED;
      w.data_byte = b;
      w.read_row = 5'($urandom);
      w.read_col = 7'($urandom);
      words_to_send.push_back(w);
   endfunction

   function automatic void queue_text(string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
   endfunction

   function automatic void queue_read(int r, int c);
      term_word_type w;
      w.op = OP_READ;
      w.data_byte = 8'($urandom);
      w.read_row = 5'(r);
      w.read_col = 7'(c);
      words_to_send.push_back(w);
   endfunction

   function automatic void queue_number(int v);
      queue_text($sformatf("%0d", v));
   endfunction

   // A random escape sequence; most are well formed with a known final byte.
   function automatic void queue_sequence();
      string finals;
      int np, k;
      finals = "ABCDHJKmsuABCDHKm";
      queue_byte(CH_ESC);
      if ($urandom_range(0, 19) == 0) begin
         queue_byte(8'($urandom));
         return;
      end
      queue_byte(CH_LBRACKET);
      k = $urandom_range(0, 29);
      np = (k == 0) ? 18 : $urandom_range(0, 3);
      for (int i = 0; i < np; i++) begin
         if (i > 0 || $urandom_range(0, 9) == 0) queue_byte(CH_SEMI);
         k = $urandom_range(0, 19);
         if (k == 0) queue_number($urandom_range(60000, 999999));
         else if (k == 1) queue_byte(8'($urandom_range(8'h3a, 8'h3f)));
         else if (k < 6) queue_number($urandom_range(0, 3));
         else if (k < 10) queue_number($urandom_range(30, 47));
         else if (k != 10) queue_number($urandom_range(0, 90));
      end
      if ($urandom_range(0, 14) == 0) queue_byte(8'($urandom_range(8'h20, 8'h2f)));
      k = $urandom_range(0, 19);
      if (k == 0) queue_byte(8'($urandom));
      else if (k == 1) queue_byte(8'($urandom_range(8'h40, 8'h7e)));
      else if (k == 2) queue_text($urandom_range(0, 3) == 0 ? "J" : "K");
      else queue_byte(finals[$urandom_range(0, finals.len() - 1)]);
   endfunction

   // Driver: bursts of words with random gaps, predicting each accepted word.
   term_word_type on_bus;
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            screen_expected.push_back(predict_screen(on_bus));
            words_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || words_to_send.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               on_bus = words_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= on_bus.op;
               req_tdata <= {4'b0, on_bus.read_col, on_bus.read_row, on_bus.data_byte};
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // Receiver: rsp_tready follows a randomly redrawn stall mode, and one long hold-off
   // holds a finished result in the engine while the driver keeps offering words.
   int  cycle_count = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   int  stall_mode = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (!hold_done && words_accepted >= 120) begin
         hold_done = 1'b1;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0, 1: rsp_tready <= 1'b1;
            2: rsp_tready <= ($urandom_range(0, 1) == 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Monitor: every result word is checked field by field against the oldest
   // expectation.
   screen_rsp_type got, want;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[7:0], rsp_tdata[10:8], rsp_tdata[13:11], rsp_tdata[14],
                rsp_tdata[19:15], rsp_tdata[26:20], rsp_tdata[27]};
         if (screen_expected.size() == 0) begin
            $error("result word with no expectation waiting: %h", rsp_tdata);
            failures++;
         end else begin
            want = screen_expected.pop_front();
            if (got.cell_char !== want.cell_char) begin
               $error("cell_char expected %h got %h", want.cell_char, got.cell_char);
               failures++;
            end
            if (got.cell_fg !== want.cell_fg) begin
               $error("cell_fg expected %0d got %0d", want.cell_fg, got.cell_fg);
               failures++;
            end
            if (got.cell_bg !== want.cell_bg) begin
               $error("cell_bg expected %0d got %0d", want.cell_bg, got.cell_bg);
               failures++;
            end
            if (got.cell_bold !== want.cell_bold) begin
               $error("cell_bold expected %0d got %0d", want.cell_bold, got.cell_bold);
               failures++;
            end
            if (got.cursor_row !== want.cursor_row) begin
               $error("cursor_row expected %0d got %0d", want.cursor_row, got.cursor_row);
               failures++;
            end
            if (got.cursor_col !== want.cursor_col) begin
               $error("cursor_col expected %0d got %0d", want.cursor_col, got.cursor_col);
               failures++;
            end
            if (got.scrolled !== want.scrolled) begin
               $error("scrolled expected %0d got %0d", want.scrolled, got.scrolled);
               failures++;
            end
         end
      end
   end

   // Watchdog: the post-reset clearing pass and a full clear screen both fit
   // well inside the idle limit.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int k;
      phase = PH_NORMAL;
      pcount = 0;
      popen = 1'b0;
      pbad = 1'b0;
      crow = 0;
      ccol = 0;
      srow = 0;
      scol = 0;
      wrap_pend = 1'b0;
      pen = ATTR_DEFAULT;
      top_row = 0;
      for (int i = 0; i < NCELLS; i++) begin
         grid_char[i] = CH_SPACE;
         grid_attr[i] = ATTR_DEFAULT;
      end

      // Directed part: controls, colour, moves with clamping and saturation,
      // delayed wrap, erase, clear, save and restore, bad and broken sequences.
      queue_read(0, 0);
      queue_text("\000\007Hi\010\011\015");
      queue_text("\033[1;31;42mA\033[mB\033[s\033[99999;200H");
      queue_text("XY\012");
      queue_text("\033[u\033[5B\033[3C\033[2A\033[9D\033[?1m\033[1 !K");
      queue_text("\033(x\033[0;;33;44;1;45;37;0;1;2;3;4;5;6;7;8;9m");
      queue_text("\033[25;80H\011Z\010\033[K\033[2J\033[3J\033[J\033[1K");
      queue_read(24, 79);
      queue_read(31, 127);
      queue_read(0, 80);

      // Random part: text runs, control bytes, sequences and reads.
      while (words_to_send.size() < 730) begin
         k = $urandom_range(0, 99);
         if (k < 35) begin
            repeat ($urandom_range(1, 40)) begin
               if ($urandom_range(0, 15) == 0) queue_byte(8'($urandom));
               else queue_byte(8'($urandom_range(8'h20, 8'h7e)));
            end
         end else if (k < 48) begin
            case ($urandom_range(0, 5))
               0: queue_byte(CH_LF);
               1: queue_byte(CH_CR);
               2: queue_byte(CH_TAB);
               3: queue_byte(CH_BS);
               4: queue_byte(CH_NUL);
               default: queue_byte(8'($urandom_range(0, 31)));
            endcase
         end else if (k < 75) begin
            if ($urandom_range(0, 39) == 0) queue_text("\033[2J");
            else queue_sequence();
         end else if (k < 78) begin
            repeat (4) queue_byte(CH_LF);
         end else if (k < 95) begin
            queue_read($urandom_range(0, NROWS - 1), $urandom_range(0, NCOLS - 1));
         end else begin
            queue_read($urandom_range(0, 31), $urandom_range(0, 127));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (words_to_send.size() != 0 || req_tvalid) @(posedge clock);
      while (screen_expected.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
